@@ sv/rmq_pkg.sv @@
// Shared types and constants for the rotation matrix to quaternion block.
// Used by the front, queue, divider, back and top-level modules.
`default_nettype none
package rmq_pkg;

    localparam int MAT_W      = 16;
    localparam int NUM_W      = 17;
    localparam int COMP_W     = 16;
    localparam int Q_W        = 16;
    localparam int DIV_STAGES = Q_W + 1;
    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_AW    = 2;

    localparam logic [1:0] PIV_REAL = 2'd0;
    localparam logic [1:0] PIV_I    = 2'd1;
    localparam logic [1:0] PIV_J    = 2'd2;
    localparam logic [1:0] PIV_K    = 2'd3;

    typedef struct packed {
        logic [1:0]              pivot;
        logic signed [NUM_W-1:0] n0;
        logic signed [NUM_W-1:0] n1;
        logic signed [NUM_W-1:0] n2;
    } t_side;

endpackage
`default_nettype wire

@@ sv/rotation_matrix_to_quaternion.sv @@
// Top level of the rotation matrix to quaternion converter.
// Depends on rmq_pkg, rmq_front, rmq_fifo and rmq_back.
//
// Converts one 3x3 rotation matrix (nine signed fixed-point entries with
// FRAC_BITS fraction bits) into the three non-pivot quaternion components,
// the pivot index and a degenerate flag. One matrix is accepted every clock
// while o_s_tready is high; results leave in order, one per matrix. The square
// root works one bit per stage and the restoring dividers have seventeen stages.
// A four-entry
// queue between the front and back parts absorbs downstream stalls.
`default_nettype none
module rotation_matrix_to_quaternion #(
    parameter int FRAC_BITS = 14
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_s_tvalid,
    output logic                      o_s_tready,
    // m00, m01, m02, m10, m11, m12, m20, m21, m22
    input  wire logic [143:0]         i_s_tdata,
    output logic                      o_m_tvalid,
    input  wire logic                 i_m_tready,
    // comp_a, comp_b, comp_c
    output logic [47:0]               o_m_tdata,
    // pivot_index, degenerate
    output logic [2:0]                o_m_tuser
);
    import rmq_pkg::*;

    localparam int SUM_W = ((FRAC_BITS > 17) ? FRAC_BITS : 17) + 1;
    localparam int QW    = SUM_W + $bits(t_side);

    logic             w_f_valid, w_f_ready, w_q_valid, w_q_ready;
    logic [SUM_W-1:0] w_f_sum;
    t_side            w_f_side, w_q_side;
    logic [QW-1:0]    w_q_data;
    logic [1:0]       w_pivot;
    logic             w_deg;

    rmq_front #(
        .FRAC_BITS (FRAC_BITS),
        .SUM_W     (SUM_W)
    ) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_s_tvalid),
        .o_ready (o_s_tready),
        .i_mat   (i_s_tdata),
        .o_valid (w_f_valid),
        .i_ready (w_f_ready),
        .o_sum   (w_f_sum),
        .o_side  (w_f_side)
    );

    rmq_fifo #(
        .WIDTH (QW)
    ) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_f_valid),
        .o_ready (w_f_ready),
        .i_data  ({w_f_sum, w_f_side}),
        .o_valid (w_q_valid),
        .i_ready (w_q_ready),
        .o_data  (w_q_data)
    );

    assign w_q_side = w_q_data[$bits(t_side)-1:0];

    rmq_back #(
        .FRAC_BITS (FRAC_BITS),
        .SUM_W     (SUM_W)
    ) u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_q_valid),
        .o_ready (w_q_ready),
        .i_sum   (w_q_data[QW-1:$bits(t_side)]),
        .i_side  (w_q_side),
        .o_valid (o_m_tvalid),
        .i_ready (i_m_tready),
        .o_comps (o_m_tdata),
        .o_pivot (w_pivot),
        .o_deg   (w_deg)
    );

    assign o_m_tuser = {w_deg, w_pivot};

endmodule
`default_nettype wire

@@ sv/rmq_front.sv @@
// Front part: picks the pivot, forms the clamped diagonal sum and the numerators.
// Depends on rmq_pkg.
`default_nettype none
module rmq_front #(
    parameter int FRAC_BITS = 14,
    parameter int SUM_W     = 18
) (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire logic                             i_valid,
    output logic                                  o_ready,
    input  wire logic [9*rmq_pkg::MAT_W-1:0]      i_mat,
    output logic                                  o_valid,
    input  wire logic                             i_ready,
    output logic [SUM_W-1:0]                      o_sum,
    output rmq_pkg::t_side                        o_side
);
    import rmq_pkg::*;

    localparam int SW = SUM_W + 1;

    logic signed [MAT_W-1:0] m00, m01, m02, m10, m11, m12, m20, m21, m22;
    logic signed [SW-1:0]    w_one, w_s;
    t_side                   w_side;
    logic [SUM_W-1:0]        w_sum;
    logic                    r_valid;
    logic [SUM_W-1:0]        r_sum;
    t_side                   r_side;

    assign m00 = i_mat[0*MAT_W +: MAT_W];
    assign m01 = i_mat[1*MAT_W +: MAT_W];
    assign m02 = i_mat[2*MAT_W +: MAT_W];
    assign m10 = i_mat[3*MAT_W +: MAT_W];
    assign m11 = i_mat[4*MAT_W +: MAT_W];
    assign m12 = i_mat[5*MAT_W +: MAT_W];
    assign m20 = i_mat[6*MAT_W +: MAT_W];
    assign m21 = i_mat[7*MAT_W +: MAT_W];
    assign m22 = i_mat[8*MAT_W +: MAT_W];

    assign w_one = SW'(1) << FRAC_BITS;

    always_comb begin
        w_side = '0;
        w_s    = '0;
        case ({m00[MAT_W-1], m11[MAT_W-1]})
            2'b00: begin
                w_side.pivot = PIV_REAL;
                w_s = w_one + SW'(m00) + SW'(m11) + SW'(m22);
                w_side.n0 = NUM_W'(m21) - NUM_W'(m12);
                w_side.n1 = NUM_W'(m02) - NUM_W'(m20);
                w_side.n2 = NUM_W'(m10) - NUM_W'(m01);
            end
            2'b01: begin
                w_side.pivot = PIV_I;
                w_s = w_one + SW'(m00) - SW'(m11) - SW'(m22);
                w_side.n0 = NUM_W'(m21) - NUM_W'(m12);
                w_side.n1 = NUM_W'(m10) + NUM_W'(m01);
                w_side.n2 = NUM_W'(m02) + NUM_W'(m20);
            end
            2'b10: begin
                w_side.pivot = PIV_J;
                w_s = w_one - SW'(m00) + SW'(m11) - SW'(m22);
                w_side.n0 = NUM_W'(m02) - NUM_W'(m20);
                w_side.n1 = NUM_W'(m10) + NUM_W'(m01);
                w_side.n2 = NUM_W'(m21) + NUM_W'(m12);
            end
            default: begin
                w_side.pivot = PIV_K;
                w_s = w_one - SW'(m00) - SW'(m11) + SW'(m22);
                w_side.n0 = NUM_W'(m10) - NUM_W'(m01);
                w_side.n1 = NUM_W'(m02) + NUM_W'(m20);
                w_side.n2 = NUM_W'(m21) + NUM_W'(m12);
            end
        endcase
        w_sum = w_s[SW-1] ? '0 : w_s[SUM_W-1:0];
    end

    assign o_ready = !r_valid || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
        if (o_ready && i_valid) begin
            r_sum  <= w_sum;
            r_side <= w_side;
        end
    end

    assign o_valid = r_valid;
    assign o_sum   = r_sum;
    assign o_side  = r_side;

endmodule
`default_nettype wire

@@ sv/rmq_fifo.sv @@
// Short queue between the front and back parts.
// Depends on rmq_pkg for its depth.
`default_nettype none
module rmq_fifo #(
    parameter int WIDTH = 8
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_valid,
    output logic                  o_ready,
    input  wire logic [WIDTH-1:0] i_data,
    output logic                  o_valid,
    input  wire logic             i_ready,
    output logic [WIDTH-1:0]      o_data
);
    import rmq_pkg::*;

    logic [WIDTH-1:0]   r_mem [0:FIFO_DEPTH-1];
    logic [FIFO_AW-1:0] r_wr, r_rd;
    logic [FIFO_AW:0]   r_cnt;
    logic               w_push, w_pop;

    assign o_ready = r_cnt != (FIFO_AW+1)'(FIFO_DEPTH);
    assign o_valid = r_cnt != '0;
    assign w_push  = i_valid && o_ready;
    assign w_pop   = o_valid && i_ready;
    assign o_data  = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (w_push) begin
                r_wr <= r_wr + 1'b1;
            end
            if (w_pop) begin
                r_rd <= r_rd + 1'b1;
            end
            if (w_push && !w_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (w_pop && !w_push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
        if (w_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

endmodule
`default_nettype wire

@@ sv/rmq_div.sv @@
// Pipelined restoring divider lane: (mag << FRAC_BITS) / den, one quotient bit a stage.
// Depends on rmq_pkg.
`default_nettype none
module rmq_div #(
    parameter int FRAC_BITS = 14,
    parameter int DEN_W     = 17
) (
    input  wire logic                      i_clk,
    input  wire logic                      i_en,
    input  wire logic [rmq_pkg::NUM_W-1:0] i_mag,
    input  wire logic                      i_neg,
    input  wire logic [DEN_W-1:0]          i_den,
    output logic [rmq_pkg::Q_W-1:0]        o_q,
    output logic                           o_ovf,
    output logic                           o_neg
);
    import rmq_pkg::*;

    localparam int DW = NUM_W + FRAC_BITS;
    localparam int CW = ((DW > DEN_W + Q_W) ? DW : DEN_W + Q_W) + 1;

    logic [CW-1:0]    r_rem [0:Q_W];
    logic [Q_W-1:0]   r_q   [0:Q_W];
    logic [DEN_W-1:0] r_den [0:Q_W];
    logic             r_ovf [0:Q_W];
    logic             r_neg [0:Q_W];
    logic [CW-1:0]    w_dvd;

    assign w_dvd = CW'(i_mag) << FRAC_BITS;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rem[0] <= w_dvd;
            r_q[0]   <= '0;
            r_den[0] <= i_den;
            r_ovf[0] <= w_dvd >= (CW'(i_den) << Q_W);
            r_neg[0] <= i_neg;
        end
    end

    for (genvar gi = 1; gi <= Q_W; gi++) begin : g_stage
        logic [CW-1:0] w_trial;
        logic          w_ge;
        assign w_trial = CW'(r_den[gi-1]) << (Q_W - gi);
        assign w_ge    = r_rem[gi-1] >= w_trial;
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[gi] <= w_ge ? r_rem[gi-1] - w_trial : r_rem[gi-1];
                r_q[gi]   <= r_q[gi-1] | (Q_W'(w_ge) << (Q_W - gi));
                r_den[gi] <= r_den[gi-1];
                r_ovf[gi] <= r_ovf[gi-1];
                r_neg[gi] <= r_neg[gi-1];
            end
        end
    end

    assign o_q   = r_q[Q_W];
    assign o_ovf = r_ovf[Q_W];
    assign o_neg = r_neg[Q_W];

endmodule
`default_nettype wire

@@ sv/rmq_back.sv @@
// Back part: pipelined square root for the pivot, three divider lanes, output register.
// Depends on rmq_pkg and rmq_div.
`default_nettype none
module rmq_back #(
    parameter int FRAC_BITS = 14,
    parameter int SUM_W     = 18
) (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire logic                                i_valid,
    output logic                                     o_ready,
    input  wire logic [SUM_W-1:0]                    i_sum,
    input  wire rmq_pkg::t_side                      i_side,
    output logic                                     o_valid,
    input  wire logic                                i_ready,
    output logic [3*rmq_pkg::COMP_W-1:0]             o_comps,
    output logic [1:0]                               o_pivot,
    output logic                                     o_deg
);
    import rmq_pkg::*;

    localparam int XW   = SUM_W + FRAC_BITS;
    localparam int XW2  = XW + (XW % 2);
    localparam int RW   = XW2 / 2;
    localparam int RMW  = RW + 2;
    localparam int DEN_W = RW + 1;
    localparam longint ONE_V   = longint'(1) << FRAC_BITS;
    localparam longint POS_V   = (ONE_V < 32767) ? ONE_V : 32767;
    localparam longint NEG_V   = (ONE_V < 32768) ? ONE_V : 32768;
    localparam logic [Q_W:0] POS_CAP = (Q_W+1)'(POS_V);
    localparam logic [Q_W:0] NEG_CAP = (Q_W+1)'(NEG_V);

    logic            w_adv;
    logic            r_sv   [0:RW];
    logic [XW2-1:0]  r_x    [0:RW];
    logic [RMW-1:0]  r_rem  [0:RW];
    logic [RW-1:0]   r_root [0:RW];
    t_side           r_side [0:RW];

    logic            r_dv   [0:Q_W];
    logic [1:0]      r_pv   [0:Q_W];
    logic            r_deg  [0:Q_W];

    logic [DEN_W-1:0]   w_den;
    logic               w_deg;
    logic [NUM_W-1:0]   w_mag [0:2];
    logic               w_neg [0:2];
    logic signed [NUM_W-1:0] w_num [0:2];
    logic [Q_W-1:0]     w_q   [0:2];
    logic               w_ovf [0:2];
    logic               w_qneg[0:2];
    logic [COMP_W-1:0]  w_comp[0:2];

    logic                 r_o_valid;
    logic [3*COMP_W-1:0]  r_comps;
    logic [1:0]           r_pivot;
    logic                 r_deg_o;

    assign w_adv   = !r_o_valid || i_ready;
    assign o_ready = w_adv;

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_x[0]    <= XW2'(i_sum) << FRAC_BITS;
            r_rem[0]  <= '0;
            r_root[0] <= '0;
            r_side[0] <= i_side;
        end
    end

    for (genvar gi = 1; gi <= RW; gi++) begin : g_sqrt
        logic [RMW-1:0] w_sh, w_trial;
        logic           w_ge;
        assign w_sh    = {r_rem[gi-1][RMW-3:0], r_x[gi-1][XW2-2*gi+1 -: 2]};
        assign w_trial = {r_root[gi-1], 2'b01};
        assign w_ge    = w_sh >= w_trial;
        always_ff @(posedge i_clk) begin
            if (w_adv) begin
                r_rem[gi]  <= w_ge ? w_sh - w_trial : w_sh;
                r_root[gi] <= {r_root[gi-1][RW-2:0], w_ge};
                r_x[gi]    <= r_x[gi-1];
                r_side[gi] <= r_side[gi-1];
            end
        end
    end

    assign w_den    = {r_root[RW][RW-1:1], 2'b00};
    assign w_deg    = r_root[RW][RW-1:1] == '0;
    assign w_num[0] = r_side[RW].n0;
    assign w_num[1] = r_side[RW].n1;
    assign w_num[2] = r_side[RW].n2;

    for (genvar gl = 0; gl < 3; gl++) begin : g_lane
        logic signed [NUM_W:0] w_wide;
        assign w_wide     = (NUM_W+1)'(w_num[gl]);
        assign w_neg[gl]  = w_num[gl][NUM_W-1];
        assign w_mag[gl]  = w_neg[gl] ? NUM_W'(-w_wide) : NUM_W'(w_wide);

        rmq_div #(
            .FRAC_BITS (FRAC_BITS),
            .DEN_W     (DEN_W)
        ) u_div (
            .i_clk (i_clk),
            .i_en  (w_adv),
            .i_mag (w_mag[gl]),
            .i_neg (w_neg[gl]),
            .i_den (w_den),
            .o_q   (w_q[gl]),
            .o_ovf (w_ovf[gl]),
            .o_neg (w_qneg[gl])
        );

        logic [Q_W:0] w_q17, w_v;
        assign w_q17 = (Q_W+1)'(w_q[gl]);
        always_comb begin
            if (w_qneg[gl]) begin
                w_v = (w_ovf[gl] || w_q17 > NEG_CAP) ? NEG_CAP : w_q17;
                w_comp[gl] = COMP_W'(-w_v);
            end else begin
                w_v = (w_ovf[gl] || w_q17 > POS_CAP) ? POS_CAP : w_q17;
                w_comp[gl] = COMP_W'(w_v);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_pv[0]  <= r_side[RW].pivot;
            r_deg[0] <= w_deg;
        end
    end

    for (genvar gd = 1; gd <= Q_W; gd++) begin : g_band
        always_ff @(posedge i_clk) begin
            if (w_adv) begin
                r_pv[gd]  <= r_pv[gd-1];
                r_deg[gd] <= r_deg[gd-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i <= RW; i++) begin
                r_sv[i] <= 1'b0;
            end
            for (int i = 0; i <= Q_W; i++) begin
                r_dv[i] <= 1'b0;
            end
            r_o_valid <= 1'b0;
        end else if (w_adv) begin
            r_sv[0] <= i_valid;
            for (int i = 1; i <= RW; i++) begin
                r_sv[i] <= r_sv[i-1];
            end
            r_dv[0] <= r_sv[RW];
            for (int i = 1; i <= Q_W; i++) begin
                r_dv[i] <= r_dv[i-1];
            end
            r_o_valid <= r_dv[Q_W];
        end
        if (w_adv) begin
            r_pivot <= r_pv[Q_W];
            r_deg_o <= r_deg[Q_W];
            r_comps <= r_deg[Q_W] ? '0 : {w_comp[2], w_comp[1], w_comp[0]};
        end
    end

    assign o_valid = r_o_valid;
    assign o_comps = r_comps;
    assign o_pivot = r_pivot;
    assign o_deg   = r_deg_o;

endmodule
`default_nettype wire

@@ tb/tb.sv @@
// Self-checking testbench for rotation_matrix_to_quaternion.
// Drives matrices on the input stream, predicts components and pivot, and
// checks every result transaction. Depends on rmq_pkg and the block's RTL.
`default_nettype none
module tb;
    import rmq_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int FRAC = 14;
    localparam longint ONE = 64'sd1 << FRAC;
    localparam int WATCHDOG = 20000;

    typedef struct packed {
        logic signed [15:0] a;
        logic signed [15:0] b;
        logic signed [15:0] c;
        logic [1:0]         piv;
        logic               degen;
    } quat_t;

    logic         i_clk = 1'b0;
    logic         i_rst_n = 1'b0;
    logic         i_s_tvalid = 1'b0;
    logic         o_s_tready;
    logic [143:0] i_s_tdata = '0;
    logic         o_m_tvalid;
    logic         i_m_tready = 1'b0;
    logic [47:0]  o_m_tdata;
    logic [2:0]   o_m_tuser;

    logic [143:0] pending_mats[$];
    quat_t        expected_quats[$];
    int           n_errors = 0;
    int           idle_cycles = 0;
    int           stall_pct = 24;
    int           sink_hold = 0;
    bit           stim_done = 0;
    bit           src_pause = 0;
    bit           in_taken = 0;

    rotation_matrix_to_quaternion #(.FRAC_BITS(FRAC)) uut (.*);

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    function automatic longint isqrt(longint x);
        longint r, b;
        r = 0;
        b = 64'sd1 << 62;
        while (b > x) b = b >>> 2;
        while (b != 0) begin
            if (x >= r + b) begin
                x = x - (r + b);
                r = (r >>> 1) + b;
            end else begin
                r = r >>> 1;
            end
            b = b >>> 2;
        end
        return r;
    endfunction

    function automatic logic signed [15:0] div_comp(longint num, longint den);
        longint mag, q;
        mag = num < 0 ? -num : num;
        q = (mag << FRAC) / den;
        if (q > ONE) q = ONE;
        if (num < 0) begin
            if (q > 32768) q = 32768;
            return 16'(-q);
        end
        if (q > 32767) q = 32767;
        return 16'(q);
    endfunction

    function automatic quat_t quat_of(logic [143:0] d);
        longint m[9];
        longint s, n0, n1, n2, p;
        quat_t r;
        for (int k = 0; k < 9; k++) m[k] = longint'($signed(d[k*16 +: 16]));
        if (m[0] >= 0 && m[4] >= 0) begin
            r.piv = PIV_REAL;
            s = ONE + m[0] + m[4] + m[8];
            n0 = m[7] - m[5]; n1 = m[2] - m[6]; n2 = m[3] - m[1];
        end else if (m[0] >= 0) begin
            r.piv = PIV_I;
            s = ONE + m[0] - m[4] - m[8];
            n0 = m[7] - m[5]; n1 = m[3] + m[1]; n2 = m[2] + m[6];
        end else if (m[4] >= 0) begin
            r.piv = PIV_J;
            s = ONE - m[0] + m[4] - m[8];
            n0 = m[2] - m[6]; n1 = m[3] + m[1]; n2 = m[7] + m[5];
        end else begin
            r.piv = PIV_K;
            s = ONE - m[0] - m[4] + m[8];
            n0 = m[3] - m[1]; n1 = m[2] + m[6]; n2 = m[7] + m[5];
        end
        if (s < 0) s = 0;
        p = isqrt(s << FRAC) >>> 1;
        if (p == 0) begin
            r.a = '0; r.b = '0; r.c = '0; r.degen = 1'b1;
        end else begin
            r.a = div_comp(n0, 4 * p);
            r.b = div_comp(n1, 4 * p);
            r.c = div_comp(n2, 4 * p);
            r.degen = 1'b0;
        end
        return r;
    endfunction

    function automatic logic [15:0] rnd_entry(int mode);
        case (mode)
            0: return 16'($urandom);
            1: return 16'($urandom_range(32768, 0) - 16384);
            default: return 16'($urandom_range(16384, 0) - 8192);
        endcase
    endfunction

    // Test matrix: mostly entries in +-1.0 with off-diagonals in +-0.5.
    function automatic logic [143:0] rnd_matrix();
        logic [143:0] d;
        int mode;
        mode = $urandom_range(9, 0);
        for (int k = 0; k < 9; k++) begin
            if (mode == 0) d[k*16 +: 16] = rnd_entry(0);
            else if (mode == 1) d[k*16 +: 16] = rnd_entry(1);
            else if (k == 0 || k == 4 || k == 8) d[k*16 +: 16] = rnd_entry(1);
            else d[k*16 +: 16] = rnd_entry(2);
        end
        return d;
    endfunction

    function automatic logic [143:0] diag(int a, int b, int c, int off);
        logic [143:0] d;
        for (int k = 0; k < 9; k++) d[k*16 +: 16] = 16'(off * (k + 1));
        d[0 +: 16] = 16'(a);
        d[64 +: 16] = 16'(b);
        d[128 +: 16] = 16'(c);
        return d;
    endfunction

    initial begin
        pending_mats.push_back(diag(16384, 16384, 16384, 0));
        pending_mats.push_back(diag(16384, -16384, -16384, 0));
        pending_mats.push_back(diag(-16384, 16384, -16384, 0));
        pending_mats.push_back(diag(-16384, -16384, 16384, 0));
        pending_mats.push_back(diag(0, 0, -16384, 100));
        pending_mats.push_back(diag(0, -1, 16384, 50));
        pending_mats.push_back(diag(0, 0, -32768, 7));
        pending_mats.push_back(diag(32767, 32767, 32767, 3000));
        pending_mats.push_back(diag(-32768, -32768, -32768, -4000));
        pending_mats.push_back(diag(0, 0, -16383, 16384));
        pending_mats.push_back(diag(-1, -1, -16383, -16384));
        pending_mats.push_back({144{1'b1}});
        pending_mats.push_back('0);
        pending_mats.push_back({9{16'h8000}});
        pending_mats.push_back({9{16'h7fff}});
        pending_mats.push_back({9{16'h5555}});
        pending_mats.push_back({9{16'haaaa}});
        for (int k = 0; k < 1800; k++) pending_mats.push_back(rnd_matrix());
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        wait (pending_mats.size() < 1200);
        src_pause = 1;
        wait (expected_quats.size() == 0 && !i_s_tvalid);
        src_pause = 0;
        wait (pending_mats.size() < 900);
        stall_pct = 0;
        wait (pending_mats.size() < 600);
        stall_pct = 24;
        sink_hold = 300;
        wait (pending_mats.size() == 0 && !i_s_tvalid);
        wait (expected_quats.size() == 0);
        repeat (60) @(posedge i_clk);
        stim_done = 1;
    end

    always @(negedge i_clk) begin
        if (i_rst_n) begin
            if (!i_s_tvalid || in_taken) begin
                if (pending_mats.size() != 0 && !src_pause &&
                    $urandom_range(99, 0) >= stall_pct) begin
                    i_s_tdata <= pending_mats.pop_front();
                    i_s_tvalid <= 1'b1;
                end else begin
                    i_s_tvalid <= 1'b0;
                end
            end
            if (sink_hold > 0) begin
                sink_hold <= sink_hold - 1;
                i_m_tready <= 1'b0;
            end else begin
                i_m_tready <= $urandom_range(99, 0) >= stall_pct;
            end
        end
    end

    always @(posedge i_clk) begin
        quat_t got, want;
        if (i_rst_n) begin
            in_taken <= i_s_tvalid && o_s_tready;
            if (i_s_tvalid && o_s_tready) expected_quats.push_back(quat_of(i_s_tdata));
            if (o_m_tvalid && i_m_tready) begin
                got = {o_m_tdata[15:0], o_m_tdata[31:16], o_m_tdata[47:32],
                       o_m_tuser[1:0], o_m_tuser[2]};
                if (expected_quats.size() == 0) begin
                    $error("result transaction with no matrix pending");
                    n_errors++;
                end else begin
                    want = expected_quats.pop_front();
                    if (got.a !== want.a) begin
                        $error("comp_a expected %0d got %0d", want.a, got.a);
                        n_errors++;
                    end
                    if (got.b !== want.b) begin
                        $error("comp_b expected %0d got %0d", want.b, got.b);
                        n_errors++;
                    end
                    if (got.c !== want.c) begin
                        $error("comp_c expected %0d got %0d", want.c, got.c);
                        n_errors++;
                    end
                    if (got.piv !== want.piv) begin
                        $error("pivot_index expected %0d got %0d", want.piv, got.piv);
                        n_errors++;
                    end
                    if (got.degen !== want.degen) begin
                        $error("degenerate expected %0d got %0d", want.degen, got.degen);
                        n_errors++;
                    end
                end
            end
            if ((i_s_tvalid && o_s_tready) || (o_m_tvalid && i_m_tready)) idle_cycles <= 0;
            else idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        wait (stim_done || idle_cycles >= WATCHDOG);
        if (stim_done && expected_quats.size() == 0 && n_errors == 0) begin
            $display("tb passed");
        end else begin
            $display("tb failed");
        end
        $finish;
    end
endmodule
`default_nettype wire
